>>> sv/mrw_pkg.sv
// Shared types and constants for the Miller-Rabin witness block.
package mrw_pkg;
  localparam int unsigned WordBits = 32;
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  typedef logic [WordBits-1:0] word_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STRIP,
    ST_MUL,
    ST_POWSTEP,
    ST_CHECK,
    ST_SQLOOP,
    ST_DONE
  } state_e;

  // Which product the shared modular multiplier forms.
  typedef enum logic [1:0] {
    MUL_ACC_SQ,
    MUL_SQ_SQ,
    MUL_X_X
  } mul_sel_e;

  typedef struct packed {
    logic     load;
    logic     red_start;
    logic     red_step;
    logic     strip_step;
    logic     mul_start;
    logic     mul_step;
    mul_sel_e mul_sel;
    logic     mul_done_acc;
    logic     exp_shift;
    logic     sq_count;
  } cmd_t;

  typedef struct packed {
    logic cand_small;
    logic red_last;
    logic u_even;
    logic mul_last;
    logic e_zero;
    logic e_lsb;
    logic x_one;
    logic x_nm1;
    logic t_zero;
  } sts_t;
endpackage

>>> sv/mrw_ctrl.sv
// Sequencer for the Miller-Rabin round.
module mrw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           out_free_i,
  input  mrw_pkg::sts_t  sts_i,
  output mrw_pkg::cmd_t  cmd_o,
  output logic           idle_o,
  output logic           done_o,
  output logic           comp_o,
  output logic           inv_o
);
  import mrw_pkg::*;

  state_e   state_q, state_d;
  mul_sel_e sel_q, sel_d;
  logic     comp_q, comp_d, inv_q, inv_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sel_q   <= MUL_ACC_SQ;
      comp_q  <= 1'b0;
      inv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      comp_q  <= comp_d;
      inv_q   <= inv_d;
    end
  end

  always_comb begin
    state_d = state_q;
    sel_d   = sel_q;
    comp_d  = comp_q;
    inv_d   = inv_q;
    case (state_q)
      ST_IDLE: if (start_i) state_d = ST_REDUCE;
      ST_REDUCE: begin
        if (sts_i.cand_small) begin
          inv_d = 1'b1; comp_d = 1'b0; state_d = ST_DONE;
        end else if (sts_i.red_last) begin
          inv_d = 1'b0; state_d = ST_STRIP;
        end
      end
      ST_STRIP: if (!sts_i.u_even) state_d = ST_POWSTEP;
      ST_POWSTEP: begin
        if (sts_i.e_zero) begin
          state_d = ST_CHECK;
        end else begin
          sel_d   = sts_i.e_lsb ? MUL_ACC_SQ : MUL_SQ_SQ;
          state_d = ST_MUL;
        end
      end
      ST_MUL: begin
        if (sts_i.mul_last) begin
          if (sel_q == MUL_ACC_SQ) begin
            sel_d = MUL_SQ_SQ;
          end else if (sel_q == MUL_SQ_SQ) begin
            state_d = ST_POWSTEP;
          end else begin
            state_d = ST_SQLOOP;
          end
        end
      end
      ST_CHECK: begin
        if (sts_i.x_one) begin
          comp_d = 1'b0; state_d = ST_DONE;
        end else begin
          state_d = ST_SQLOOP;
        end
      end
      ST_SQLOOP: begin
        if (sts_i.t_zero) begin
          comp_d = 1'b1; state_d = ST_DONE;
        end else if (sts_i.x_nm1) begin
          comp_d = 1'b0; state_d = ST_DONE;
        end else begin
          sel_d = MUL_X_X; state_d = ST_MUL;
        end
      end
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    cmd_o.mul_sel = sel_q;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = start_i;
        cmd_o.red_start = start_i;
      end
      ST_REDUCE: cmd_o.red_step = 1'b1;
      ST_STRIP:  cmd_o.strip_step = sts_i.u_even;
      ST_POWSTEP: if (!sts_i.e_zero) begin
        // pick the operands of the product that starts now
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = sts_i.e_lsb ? MUL_ACC_SQ : MUL_SQ_SQ;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        if (sts_i.mul_last) begin
          cmd_o.mul_done_acc = 1'b1;
          if (sel_q == MUL_ACC_SQ) cmd_o.mul_start = 1'b1;
          if (sel_q == MUL_SQ_SQ) cmd_o.exp_shift = 1'b1;
        end
      end
      ST_SQLOOP: if (!sts_i.t_zero && !sts_i.x_nm1) begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_X_X;
        cmd_o.sq_count  = 1'b1;
      end
      default: ;
    endcase
  end

  assign idle_o = (state_q == ST_IDLE);
  assign done_o = (state_q == ST_DONE);
  assign comp_o = comp_q;
  assign inv_o  = inv_q;
endmodule

>>> sv/mrw_dp.sv
// Datapath: base reduction, exponent split and shift-and-add modular multiplier.
module mrw_dp (
  input  logic            clk_i,
  input  mrw_pkg::word_t  cand_i,
  input  mrw_pkg::word_t  base_i,
  input  mrw_pkg::cmd_t   cmd_i,
  output mrw_pkg::sts_t   sts_o
);
  import mrw_pkg::*;

  word_t n_q, a_q, e_q, acc_q, sq_q;
  word_t rem_q, m_q, p_q, px_q, py_q;
  logic [CntBits-1:0] bit_q, t_q;

  // (x + y) mod n for x, y < n
  function automatic word_t add_mod(word_t x, word_t y, word_t n);
    word_t room;
    room = n - y;
    return (x >= room) ? (x - room) : (x + y);
  endfunction

  // One restoring-division step of a mod n; the shifted value needs one extra bit.
  logic [WordBits:0] rem_sh;
  assign rem_sh = {rem_q, a_q[WordBits-1 - bit_q[CntBits-2:0]]};

  word_t p_dbl, p_nxt, mx, my;
  assign p_dbl = add_mod(p_q, p_q, n_q);
  assign p_nxt = py_q[WordBits-1] ? add_mod(p_dbl, px_q, n_q) : p_dbl;

  always_comb begin
    case (cmd_i.mul_sel)
      MUL_ACC_SQ: begin mx = sq_q; my = acc_q; end
      MUL_SQ_SQ:  begin mx = sq_q; my = sq_q;  end
      default:    begin mx = acc_q; my = acc_q; end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q <= cand_i;
      a_q <= base_i;
      t_q <= '0;
    end
    if (cmd_i.red_start) begin
      rem_q <= '0;
      bit_q <= '0;
    end
    if (cmd_i.red_step) begin
      rem_q <= (rem_sh >= {1'b0, n_q}) ? word_t'(rem_sh - {1'b0, n_q})
                                        : rem_sh[WordBits-1:0];
      bit_q <= bit_q + 1'b1;
      if (sts_o.red_last) begin
        e_q   <= n_q - 1'b1;
        acc_q <= word_t'(1);
      end
    end
    if (cmd_i.strip_step) begin
      e_q <= e_q >> 1;
      t_q <= t_q + 1'b1;
    end
    if (cmd_i.red_step && sts_o.red_last) begin
      // sq holds the reduced base once the last step lands
      sq_q <= (rem_sh >= {1'b0, n_q}) ? word_t'(rem_sh - {1'b0, n_q})
                                       : rem_sh[WordBits-1:0];
    end
    if (cmd_i.mul_step && cmd_i.mul_done_acc) begin
      case (cmd_i.mul_sel)
        MUL_SQ_SQ: sq_q  <= p_nxt;
        default:   acc_q <= p_nxt;
      endcase
    end
    if (cmd_i.mul_start) begin
      p_q  <= '0;
      m_q  <= '0;
      if (cmd_i.mul_step) begin
        // acc*sq just finished; next product is sq*sq
        px_q <= sq_q;
        py_q <= sq_q;
      end else begin
        px_q <= mx;
        py_q <= my;
      end
    end else if (cmd_i.mul_step) begin
      p_q  <= p_nxt;
      py_q <= py_q << 1;
      m_q  <= m_q + 1'b1;
    end
    if (cmd_i.exp_shift) e_q <= e_q >> 1;
    if (cmd_i.sq_count)  t_q <= t_q - 1'b1;
  end

  assign sts_o.cand_small = (n_q < word_t'(3));
  assign sts_o.red_last   = (bit_q == CntBits'(WordBits - 1));
  assign sts_o.u_even     = ~e_q[0];
  assign sts_o.mul_last   = (m_q == word_t'(WordBits - 1));
  assign sts_o.e_zero     = (e_q == '0);
  assign sts_o.e_lsb      = e_q[0];
  assign sts_o.x_one      = (acc_q == word_t'(1));
  assign sts_o.x_nm1      = (acc_q == n_q - 1'b1);
  assign sts_o.t_zero     = (t_q == '0);
endmodule

>>> sv/miller_rabin_witness.sv
// Top level of the Miller-Rabin witness round.
// One round per word: the base is reduced mod n by a bit-serial divider, factors of
// two are stripped from n-1 (one per cycle), then a^u mod n and up to t squarings run
// on one shift-and-add modular multiplier, one product at a time. A 32-bit candidate
// needs at most 63 products; candidates below 3 finish as invalid without the
// reduction. One word is in flight at a time; the result is held until taken on the
// master side.
module miller_rabin_witness (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] candidate, [63:32] base
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [0] composite, [1] invalid, [7:2] zero
);
  import mrw_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic idle, done, comp, inv, start;

  assign start = s_axis_tvalid && idle;
  assign s_axis_tready = idle;

  mrw_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .out_free_i(m_axis_tready),
    .sts_i(sts), .cmd_o(cmd), .idle_o(idle), .done_o(done),
    .comp_o(comp), .inv_o(inv)
  );

  mrw_dp u_dp (
    .clk_i, .cand_i(s_axis_tdata[31:0]), .base_i(s_axis_tdata[63:32]),
    .cmd_i(cmd), .sts_o(sts)
  );

  assign m_axis_tvalid = done;
  assign m_axis_tdata  = {6'b0, inv, comp};

  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid)) else $error("accept while result pending");
  a_inv_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("invalid and composite both set");
  a_ret_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
    else $error("not idle after result taken");
endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the Miller-Rabin witness round.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import mrw_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;   // [31:0] candidate, [63:32] base
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [0] composite, [1] invalid, [7:2] zero

  // candidate lands in the low half of the word
  typedef struct packed {
    word_t base;
    word_t candidate;
  } test_t;

  typedef struct packed {
    logic composite;
    logic invalid;
  } verdict_t;

  test_t    pending_tests[$];
  verdict_t expected_verdicts[$];
  int       fail_count;
  int       send_gap;
  int       recv_gap;
  bit       stim_done;

  miller_rabin_witness i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // (x + y) mod n, operands below n
  function automatic word_t add_mod(word_t x, word_t y, word_t n);
    word_t room;
    room = n - y;
    return (x >= room) ? x - room : x + y;
  endfunction

  function automatic word_t mul_mod(word_t x, word_t y, word_t n);
    word_t acc;
    acc = '0;
    for (int k = WordBits - 1; k >= 0; k--) begin
      acc = add_mod(acc, acc, n);
      if (y[k]) acc = add_mod(acc, x, n);
    end
    return acc;
  endfunction

  function automatic verdict_t predict_verdict(test_t tst);
    verdict_t v;
    word_t    n, a, u, x, acc, sq;
    int       twos;
    n = tst.candidate;
    v = '0;
    if (n < 3) begin
      v.invalid = 1'b1;
      return v;
    end
    a = tst.base % n;
    u = n - 1;
    twos = 0;
    while (!u[0]) begin
      u = u >> 1;
      twos++;
    end
    acc = 1;
    sq = a;
    while (u != 0) begin
      if (u[0]) acc = mul_mod(acc, sq, n);
      sq = mul_mod(sq, sq, n);
      u = u >> 1;
    end
    x = acc;
    v.composite = 1'b1;
    if (x == 1) begin
      v.composite = 1'b0;
    end else begin
      for (int i = 0; i < twos; i++) begin
        if (x == n - 1) begin
          v.composite = 1'b0;
          break;
        end
        x = mul_mod(x, x, n);
      end
    end
    return v;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 3000);
  endfunction

  function automatic word_t odd_word();
    word_t w;
    w = $urandom();
    case ($urandom_range(0, 3))
      0: w = w & 32'h0000_0fff;
      1: w = w & 32'h00ff_ffff;
      default: ;
    endcase
    return w | 32'h1;
  endfunction

  task automatic add_test(word_t n, word_t a);
    test_t tst;
    tst.candidate = n;
    tst.base = a;
    pending_tests.push_back(tst);
  endtask

  initial begin
    word_t n;
    word_t p_list[8];
    p_list = '{32'd3, 32'd5, 32'd97, 32'd7919, 32'd65537, 32'd2147483647,
               32'd4294967291, 32'd1000000007};
    // small, zero-base, even, large-base, extremes
    add_test(32'd0, 32'd5);
    add_test(32'd1, 32'hffff_ffff);
    add_test(32'd2, 32'd1);
    add_test(32'd3, 32'd2);
    add_test(32'd4, 32'd3);
    add_test(32'd9, 32'd9);
    add_test(32'd9, 32'd0);
    add_test(32'd561, 32'd2);
    add_test(32'd341, 32'd2);
    add_test(32'd2047, 32'd2);
    add_test(32'd25, 32'd7);
    add_test(32'd25, 32'd24);
    add_test(32'd100, 32'd1);
    add_test(32'hffff_fffe, 32'hffff_fffd);
    add_test(32'hffff_ffff, 32'hffff_ffff);
    add_test(32'hffff_fffb, 32'hffff_ffff);
    add_test(32'hffff_fffb, 32'hffff_fffa);
    add_test(32'h8000_0001, 32'h8000_0000);
    add_test(32'd2147483647, 32'd3);
    add_test(32'd13, 32'd12);
    add_test(32'd13, 32'd1);
    for (int i = 0; i < 270; i++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: add_test(p_list[$urandom_range(0, 7)], $urandom());
        3:       add_test($urandom_range(0, 8), $urandom());
        4:       add_test($urandom(), $urandom());
        5: begin
          n = odd_word();
          add_test(n, ($urandom_range(0, 1) != 0) ? n - 1 : n);
        end
        default: add_test(odd_word() | 32'h2, $urandom());
      endcase
    end
  end

  initial begin
    fail_count = 0;
    stim_done = 1'b0;
    send_gap = 0;
    recv_gap = 0;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // driver: hold word until accepted, then gap or advance
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_verdicts.push_back(predict_verdict(s_axis_tdata));
        send_gap = pick_gap();
      end
      if (s_axis_tvalid && !s_axis_tready) begin
        // hold
      end else if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_tests.size() > 0) begin
        s_axis_tdata  <= pending_tests.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
      end
    end
  end

  // monitor: compare each result word with the oldest prediction
  always @(posedge clk_i) begin
    verdict_t exp_v;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_verdicts.size() == 0) begin
          $error("unexpected result word %h", m_axis_tdata);
          fail_count++;
        end else begin
          exp_v = expected_verdicts.pop_front();
          if (m_axis_tdata[0] !== exp_v.composite) begin
            $error("composite: expected %b actual %b", exp_v.composite, m_axis_tdata[0]);
            fail_count++;
          end
          if (m_axis_tdata[1] !== exp_v.invalid) begin
            $error("invalid: expected %b actual %b", exp_v.invalid, m_axis_tdata[1]);
            fail_count++;
          end
        end
      end
      if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else begin
        recv_gap = pick_gap();
        m_axis_tready <= (recv_gap == 0);
      end
    end
  end

  initial begin
    wait (stim_done && expected_verdicts.size() == 0);
    repeat (2200) @(posedge clk_i);
    if (fail_count == 0 && expected_verdicts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #250ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule

>>> sim.f
sv/mrw_pkg.sv
sv/mrw_ctrl.sv
sv/mrw_dp.sv
sv/miller_rabin_witness.sv
tb/sv/testbench.sv
